// ----- hdl/eksc_pkg.sv -----
// ----------------------------------------------------------------------------
// eksc_pkg
// Shared widths, register map, codes and types for the knob setting
// controller.
// ----------------------------------------------------------------------------
package eksc_pkg;

  localparam int TIME_W   = 32;
  localparam int ATTEN_W  = 6;
  localparam int PHASE_W  = 10;
  localparam int STEP_W   = 3;
  localparam int DEB_W    = 8;
  localparam int LONG_W   = 16;
  localparam int PADDR_W  = 4;
  localparam int PDATA_W  = 32;
  localparam int HIST_W   = 4;

  localparam logic [ATTEN_W-1:0] ATTEN_MAX = '1;

  localparam logic [HIST_W-1:0] HIST_UP   = 4'h6;
  localparam logic [HIST_W-1:0] HIST_DOWN = 4'hC;

  typedef logic [PADDR_W-3:0] reg_idx_t;
  localparam reg_idx_t REG_DEBOUNCE   = 2'd0;
  localparam reg_idx_t REG_LONG_PRESS = 2'd1;
  localparam reg_idx_t REG_PHASE_MOD  = 2'd2;

  localparam logic [DEB_W-1:0]   DEBOUNCE_RST   = 8'd10;
  localparam logic [LONG_W-1:0]  LONG_PRESS_RST = 16'd1000;
  localparam logic [PHASE_W-1:0] PHASE_MOD_RST  = 10'd360;

  localparam logic [STEP_W-1:0] STEP_ONE  = 3'd1;
  localparam logic [STEP_W-1:0] STEP_TWO  = 3'd2;
  localparam logic [STEP_W-1:0] STEP_FOUR = 3'd4;

  typedef struct packed {
    logic up;
    logic down;
  } knob_step_t;

  typedef struct packed {
    logic short_rel;
    logic long_rel;
    logic held_long;
  } button_evt_t;

  typedef struct packed {
    logic              up;
    logic              down;
    logic [STEP_W-1:0] step;
  } phase_cmd_t;

  typedef enum logic {
    PH_IDLE,
    PH_REDUCE
  } ph_state_e;

endpackage

// ----- hdl/eksc_knob.sv -----
// ----------------------------------------------------------------------------
// eksc_knob
// Quadrature decoder for one knob: history shifts on every enabled A change.
// ----------------------------------------------------------------------------
module eksc_knob (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                a_i,
  input  logic                b_i,
  output eksc_pkg::knob_step_t step_o
);

  logic                         last_a_q;
  logic [eksc_pkg::HIST_W-1:0]  hist_q;
  logic [eksc_pkg::HIST_W-1:0]  hist_d;
  logic                         changed;

  assign changed = (a_i != last_a_q);
  assign hist_d  = {hist_q[eksc_pkg::HIST_W-3:0], b_i, a_i};

  assign step_o.up   = changed && (hist_d == eksc_pkg::HIST_UP);
  assign step_o.down = changed && (hist_d == eksc_pkg::HIST_DOWN);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_a_q <= 1'b0;
      hist_q   <= '0;
    end else if (en_i && changed) begin
      last_a_q <= a_i;
      hist_q   <= hist_d;
    end
  end

endmodule

// ----- hdl/eksc_button.sv -----
// ----------------------------------------------------------------------------
// eksc_button
// Time-based debounce of one push button, classing each release short or
// long and flagging a press held past the long threshold.
// ----------------------------------------------------------------------------
module eksc_button (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          level_i,
  input  logic [eksc_pkg::TIME_W-1:0]   t_i,
  input  logic [eksc_pkg::DEB_W-1:0]    debounce_i,
  input  logic [eksc_pkg::LONG_W-1:0]   long_press_i,
  output eksc_pkg::button_evt_t         evt_o
);

  logic                        down_q;
  logic                        down_d;
  logic [eksc_pkg::TIME_W-1:0] press_q;
  logic [eksc_pkg::TIME_W-1:0] release_q;
  logic [eksc_pkg::TIME_W-1:0] since_rel;
  logic [eksc_pkg::TIME_W-1:0] since_press;
  logic [eksc_pkg::TIME_W-1:0] deb_ext;
  logic [eksc_pkg::TIME_W-1:0] long_ext;
  logic                        press_edge;
  logic                        rel_edge;
  logic                        press_ok;
  logic                        rel_ok;
  logic                        is_long;

  assign deb_ext  = {{(eksc_pkg::TIME_W-eksc_pkg::DEB_W){1'b0}}, debounce_i};
  assign long_ext = {{(eksc_pkg::TIME_W-eksc_pkg::LONG_W){1'b0}}, long_press_i};

  // differences wrap with the time counter
  assign since_rel   = t_i - release_q;
  assign since_press = t_i - press_q;

  assign press_edge = level_i && !down_q;
  assign rel_edge   = !level_i && down_q;
  assign press_ok   = since_rel > deb_ext;
  assign rel_ok     = since_press > deb_ext;
  assign is_long    = since_press > long_ext;

  always_comb begin
    down_d = down_q;
    if (press_edge && press_ok) begin
      down_d = 1'b1;
    end else if (rel_edge && rel_ok) begin
      down_d = 1'b0;
    end
  end

  assign evt_o.short_rel = rel_edge && rel_ok && !is_long;
  assign evt_o.long_rel  = rel_edge && rel_ok && is_long;
  // a fresh press restarts the press time, so it cannot be long yet
  assign evt_o.held_long = down_d && !press_edge && is_long;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      down_q    <= 1'b0;
      press_q   <= '0;
      release_q <= '0;
    end else if (en_i) begin
      down_q <= down_d;
      if (press_edge) begin
        press_q <= t_i;
      end
      if (rel_edge) begin
        release_q <= t_i;
      end
    end
  end

endmodule

// ----- hdl/eksc_phase.sv -----
// ----------------------------------------------------------------------------
// eksc_phase
// Phase setting with wrap. Keeps the phase residue mod the modulus alongside
// the phase so an up step that overflows needs no divider; a modulus write
// rebuilds the residue by restoring division, one bit per cycle.
// ----------------------------------------------------------------------------
module eksc_phase (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  eksc_pkg::phase_cmd_t          cmd_i,
  input  logic [eksc_pkg::PHASE_W-1:0]  modulus_i,
  input  logic                          start_i,
  output logic [eksc_pkg::PHASE_W-1:0]  phase_o,
  output logic                          busy_o
);

  localparam int CNT_W   = $clog2(eksc_pkg::PHASE_W);
  localparam int RED_N   = 4;  // largest step over smallest nonzero modulus
  localparam int SW      = eksc_pkg::PHASE_W + 2;
  localparam int WRAP_M3 = (1 << eksc_pkg::PHASE_W) % 3;

  eksc_pkg::ph_state_e state_q, state_d;

  logic [eksc_pkg::PHASE_W-1:0] phase_q, phase_d;
  logic [eksc_pkg::PHASE_W-1:0] res_q, res_d;
  logic [eksc_pkg::PHASE_W-1:0] div_q, div_d;
  logic [CNT_W-1:0]             cnt_q, cnt_d;

  logic [eksc_pkg::PHASE_W:0]   mod_ext;
  logic [eksc_pkg::PHASE_W:0]   sum;
  logic [eksc_pkg::PHASE_W:0]   res_up;
  logic signed [SW-1:0]         mod_s;
  logic signed [SW-1:0]         step_s;
  logic signed [SW-1:0]         diff;
  logic signed [SW-1:0]         diff_wrap;
  logic signed [SW-1:0]         res_dn;
  logic [eksc_pkg::PHASE_W-1:0] phase_up;
  logic [eksc_pkg::PHASE_W-1:0] phase_dn;
  logic [eksc_pkg::PHASE_W:0]   shifted;
  logic [eksc_pkg::PHASE_W-1:0] red_bit;

  assign mod_ext = {1'b0, modulus_i};
  assign mod_s   = $signed({2'b00, modulus_i});
  assign step_s  = $signed({{(SW-eksc_pkg::STEP_W){1'b0}}, cmd_i.step});

  // step up
  always_comb begin
    sum    = {1'b0, phase_q} + {{(eksc_pkg::PHASE_W+1-eksc_pkg::STEP_W){1'b0}}, cmd_i.step};
    res_up = {1'b0, res_q} + {{(eksc_pkg::PHASE_W+1-eksc_pkg::STEP_W){1'b0}}, cmd_i.step};
    for (int i = 0; i < RED_N; i++) begin
      if (res_up >= mod_ext) begin
        res_up = res_up - mod_ext;
      end
    end
    if (modulus_i == '0) begin
      phase_up = sum[eksc_pkg::PHASE_W-1:0];
    end else if (sum > mod_ext) begin
      phase_up = res_up[eksc_pkg::PHASE_W-1:0];
    end else begin
      phase_up = sum[eksc_pkg::PHASE_W-1:0];
    end
  end

  // step down; a result still negative after adding the modulus wraps
  // to the phase width, which shifts the residue by 2^W mod m (m <= 3 then)
  always_comb begin
    diff      = $signed({2'b00, phase_q}) - step_s;
    diff_wrap = diff + mod_s;
    res_dn    = $signed({2'b00, res_q}) - step_s;
    for (int i = 0; i < RED_N; i++) begin
      if (res_dn < 0) begin
        res_dn = res_dn + mod_s;
      end
    end
    if (diff < 0 && diff_wrap < 0 && modulus_i == eksc_pkg::PHASE_W'(3)) begin
      res_dn = res_dn + SW'(WRAP_M3);
      if (res_dn >= mod_s) begin
        res_dn = res_dn - mod_s;
      end
    end
    if (diff < 0) begin
      phase_dn = diff_wrap[eksc_pkg::PHASE_W-1:0];
    end else begin
      phase_dn = diff[eksc_pkg::PHASE_W-1:0];
    end
  end

  // one restoring-division bit
  always_comb begin
    shifted = {res_q, div_q[eksc_pkg::PHASE_W-1]};
    if (shifted >= mod_ext) begin
      red_bit = eksc_pkg::PHASE_W'(shifted - mod_ext);
    end else begin
      red_bit = shifted[eksc_pkg::PHASE_W-1:0];
    end
  end

  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    res_d   = res_q;
    div_d   = div_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      eksc_pkg::PH_IDLE: begin
        if (start_i) begin
          state_d = eksc_pkg::PH_REDUCE;
          res_d   = '0;
          div_d   = phase_q;
          cnt_d   = '0;
        end else if (en_i && cmd_i.up) begin
          phase_d = phase_up;
          res_d   = res_up[eksc_pkg::PHASE_W-1:0];
        end else if (en_i && cmd_i.down) begin
          phase_d = phase_dn;
          res_d   = res_dn[eksc_pkg::PHASE_W-1:0];
        end
      end
      eksc_pkg::PH_REDUCE: begin
        res_d = red_bit;
        div_d = div_q << 1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(eksc_pkg::PHASE_W - 1)) begin
          state_d = eksc_pkg::PH_IDLE;
        end
      end
      default: begin
        state_d = eksc_pkg::PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= eksc_pkg::PH_IDLE;
      phase_q <= '0;
      res_q   <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      res_q   <= res_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    div_q <= div_d;
  end

  assign phase_o = phase_d;
  assign busy_o  = (state_q == eksc_pkg::PH_REDUCE);

  a_res_below_mod: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!busy_o && modulus_i != '0) |-> (res_q < modulus_i))
    else $error("phase residue not below modulus");

  a_no_step_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |-> !en_i)
    else $error("phase step while residue rebuild runs");

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("modulus write did not start residue rebuild");

endmodule

// ----- hdl/encoder_knob_setting_controller_top.sv -----
// ----------------------------------------------------------------------------
// encoder_knob_setting_controller_top
// Two quadrature knobs with push buttons driving phase and attenuation
// settings, with an APB-style register port.
// ----------------------------------------------------------------------------
// Each input beat is one 1 ms sample of both knobs and buttons; every beat
// yields one result beat. Beats are taken one per clock unless the output
// stalls or a rebuild runs; a sample passes the input register, then the
// result register. A write to phase_modulus rebuilds the stored phase residue
// with a bit-serial divider; in_ready_o stays low during that write and rebuild.
module encoder_knob_setting_controller_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // APB-style configuration port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [eksc_pkg::PADDR_W-1:0]    paddr,
  input  logic [eksc_pkg::PDATA_W-1:0]    pwdata,
  output logic [eksc_pkg::PDATA_W-1:0]    prdata,
  output logic                            pready,
  // sample channel
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            amp_enc_a_i,
  input  logic                            amp_enc_b_i,
  input  logic                            amp_button_i,
  input  logic                            phase_enc_a_i,
  input  logic                            phase_enc_b_i,
  input  logic                            phase_button_i,
  // result channel
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [eksc_pkg::PHASE_W-1:0]    phase_degrees_o,
  output logic [eksc_pkg::ATTEN_W-1:0]    drive_level_o,
  output logic [eksc_pkg::ATTEN_W-1:0]    demod_level_o,
  output logic [eksc_pkg::ATTEN_W-1:0]    drive_pins_o,
  output logic [eksc_pkg::ATTEN_W-1:0]    demod_pins_o,
  output logic                            amp_editing_o,
  output logic                            phase_editing_o,
  output logic                            demod_selected_o,
  output logic [eksc_pkg::STEP_W-1:0]     phase_step_o,
  output logic                            amp_held_long_o,
  output logic                            phase_held_long_o
);

  // configuration registers
  logic [eksc_pkg::DEB_W-1:0]    debounce_q;
  logic [eksc_pkg::LONG_W-1:0]   long_press_q;
  logic [eksc_pkg::PHASE_W-1:0]  phase_mod_q;
  logic                          cfg_wr;
  logic                          mod_wr;
  eksc_pkg::reg_idx_t            reg_idx;

  // input stage
  logic s1_valid_q;
  logic s1_adv;
  logic in_acc;
  logic s1_amp_a_q, s1_amp_b_q, s1_amp_btn_q;
  logic s1_ph_a_q, s1_ph_b_q, s1_ph_btn_q;

  // settings state
  logic [eksc_pkg::TIME_W-1:0]  now_q;
  logic                         amp_edit_q, amp_edit_d;
  logic                         phase_edit_q, phase_edit_d;
  logic                         demod_sel_q, demod_sel_d;
  logic [eksc_pkg::STEP_W-1:0]  step_q, step_d;
  logic [eksc_pkg::ATTEN_W-1:0] drive_q, drive_d;
  logic [eksc_pkg::ATTEN_W-1:0] demod_q, demod_d;
  logic [eksc_pkg::ATTEN_W-1:0] atten_cur;
  logic [eksc_pkg::ATTEN_W-1:0] atten_new;

  eksc_pkg::knob_step_t  amp_step, ph_step;
  eksc_pkg::button_evt_t amp_evt, ph_evt;
  eksc_pkg::phase_cmd_t  ph_cmd;
  logic [eksc_pkg::PHASE_W-1:0] phase_next;
  logic                         ph_busy;

  // result register
  logic                          out_valid_q;
  logic [eksc_pkg::PHASE_W-1:0]  out_phase_q;
  logic [eksc_pkg::ATTEN_W-1:0]  out_drive_q;
  logic [eksc_pkg::ATTEN_W-1:0]  out_demod_q;
  logic                          out_amp_edit_q;
  logic                          out_phase_edit_q;
  logic                          out_demod_sel_q;
  logic [eksc_pkg::STEP_W-1:0]   out_step_q;
  logic                          out_amp_held_q;
  logic                          out_ph_held_q;

  // ---------------------------------------------------------------- config
  assign pready  = 1'b1;
  assign reg_idx = paddr[eksc_pkg::PADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite;
  assign mod_wr  = cfg_wr && (reg_idx == eksc_pkg::REG_PHASE_MOD);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q   <= eksc_pkg::DEBOUNCE_RST;
      long_press_q <= eksc_pkg::LONG_PRESS_RST;
      phase_mod_q  <= eksc_pkg::PHASE_MOD_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        eksc_pkg::REG_DEBOUNCE:   debounce_q   <= pwdata[eksc_pkg::DEB_W-1:0];
        eksc_pkg::REG_LONG_PRESS: long_press_q <= pwdata[eksc_pkg::LONG_W-1:0];
        eksc_pkg::REG_PHASE_MOD:  phase_mod_q  <= pwdata[eksc_pkg::PHASE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      eksc_pkg::REG_DEBOUNCE:
        prdata = {{(eksc_pkg::PDATA_W-eksc_pkg::DEB_W){1'b0}}, debounce_q};
      eksc_pkg::REG_LONG_PRESS:
        prdata = {{(eksc_pkg::PDATA_W-eksc_pkg::LONG_W){1'b0}}, long_press_q};
      eksc_pkg::REG_PHASE_MOD:
        prdata = {{(eksc_pkg::PDATA_W-eksc_pkg::PHASE_W){1'b0}}, phase_mod_q};
      default:
        prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- input stage
  assign s1_adv     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = (!s1_valid_q || s1_adv) && !ph_busy && !mod_wr;
  assign in_acc     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_acc) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_amp_a_q   <= amp_enc_a_i;
      s1_amp_b_q   <= amp_enc_b_i;
      s1_amp_btn_q <= amp_button_i;
      s1_ph_a_q    <= phase_enc_a_i;
      s1_ph_b_q    <= phase_enc_b_i;
      s1_ph_btn_q  <= phase_button_i;
    end
  end

  // ---------------------------------------------------------------- knobs, buttons
  eksc_knob u_amp_knob (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (s1_adv),
    .a_i    (s1_amp_a_q),
    .b_i    (s1_amp_b_q),
    .step_o (amp_step)
  );

  eksc_knob u_ph_knob (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (s1_adv),
    .a_i    (s1_ph_a_q),
    .b_i    (s1_ph_b_q),
    .step_o (ph_step)
  );

  eksc_button u_amp_btn (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (s1_adv),
    .level_i      (s1_amp_btn_q),
    .t_i          (now_q),
    .debounce_i   (debounce_q),
    .long_press_i (long_press_q),
    .evt_o        (amp_evt)
  );

  eksc_button u_ph_btn (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (s1_adv),
    .level_i      (s1_ph_btn_q),
    .t_i          (now_q),
    .debounce_i   (debounce_q),
    .long_press_i (long_press_q),
    .evt_o        (ph_evt)
  );

  // ---------------------------------------------------------------- phase
  // knob steps act under the edit modes held before this sample's releases
  assign ph_cmd.up   = ph_step.up && phase_edit_q;
  assign ph_cmd.down = ph_step.down && phase_edit_q;
  assign ph_cmd.step = step_q;

  eksc_phase u_phase (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (s1_adv),
    .cmd_i     (ph_cmd),
    .modulus_i (phase_mod_q),
    .start_i   (mod_wr),
    .phase_o   (phase_next),
    .busy_o    (ph_busy)
  );

  // ---------------------------------------------------------------- attenuation, modes
  assign atten_cur = demod_sel_q ? demod_q : drive_q;

  always_comb begin
    atten_new = atten_cur;
    if (amp_edit_q && amp_step.up && atten_cur != eksc_pkg::ATTEN_MAX) begin
      atten_new = atten_cur + 1'b1;
    end else if (amp_edit_q && amp_step.down && atten_cur != '0) begin
      atten_new = atten_cur - 1'b1;
    end
  end

  always_comb begin
    drive_d      = drive_q;
    demod_d      = demod_q;
    amp_edit_d   = amp_edit_q;
    phase_edit_d = phase_edit_q;
    demod_sel_d  = demod_sel_q;
    step_d       = step_q;
    if (s1_adv) begin
      if (demod_sel_q) begin
        demod_d = atten_new;
      end else begin
        drive_d = atten_new;
      end
      if (amp_evt.long_rel) begin
        amp_edit_d = !amp_edit_q;
      end else if (amp_evt.short_rel && amp_edit_q) begin
        demod_sel_d = !demod_sel_q;
      end
      if (ph_evt.long_rel) begin
        phase_edit_d = !phase_edit_q;
        step_d       = eksc_pkg::STEP_ONE;
      end else if (ph_evt.short_rel && phase_edit_q) begin
        case (step_q)
          eksc_pkg::STEP_ONE: step_d = eksc_pkg::STEP_TWO;
          eksc_pkg::STEP_TWO: step_d = eksc_pkg::STEP_FOUR;
          default:            step_d = eksc_pkg::STEP_ONE;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      now_q        <= '0;
      drive_q      <= '0;
      demod_q      <= '0;
      amp_edit_q   <= 1'b0;
      phase_edit_q <= 1'b0;
      demod_sel_q  <= 1'b0;
      step_q       <= eksc_pkg::STEP_ONE;
    end else begin
      if (s1_adv) begin
        now_q <= now_q + 1'b1;
      end
      drive_q      <= drive_d;
      demod_q      <= demod_d;
      amp_edit_q   <= amp_edit_d;
      phase_edit_q <= phase_edit_d;
      demod_sel_q  <= demod_sel_d;
      step_q       <= step_d;
    end
  end

  // ---------------------------------------------------------------- result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_phase_q      <= phase_next;
      out_drive_q      <= drive_d;
      out_demod_q      <= demod_d;
      out_amp_edit_q   <= amp_edit_d;
      out_phase_edit_q <= phase_edit_d;
      out_demod_sel_q  <= demod_sel_d;
      out_step_q       <= step_d;
      out_amp_held_q   <= amp_evt.held_long;
      out_ph_held_q    <= ph_evt.held_long;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign phase_degrees_o   = out_phase_q;
  assign drive_level_o     = out_drive_q;
  assign demod_level_o     = out_demod_q;
  assign drive_pins_o      = ~out_drive_q;
  assign demod_pins_o      = ~out_demod_q;
  assign amp_editing_o     = out_amp_edit_q;
  assign phase_editing_o   = out_phase_edit_q;
  assign demod_selected_o  = out_demod_sel_q;
  assign phase_step_o      = out_step_q;
  assign amp_held_long_o   = out_amp_held_q;
  assign phase_held_long_o = out_ph_held_q;

  // ---------------------------------------------------------------- checks
  a_busy_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ph_busy |-> !in_ready_o)
    else $error("sample taken during residue rebuild");

  a_step_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(step_q))
    else $error("phase step not 1, 2 or 4");

  a_long_toggles: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && amp_evt.long_rel) |=> (amp_edit_q != $past(amp_edit_q)))
    else $error("long amp release did not toggle edit mode");

  a_mod_wr_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mod_wr && !ph_busy) |=> ph_busy)
    else $error("modulus write did not stall the sample channel");

endmodule
